>>> rtl/accel_tap_gesture_detector_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the accelerometer tap detector
// Concurrent checks that fold away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ACCEL_TAP_GESTURE_DETECTOR_MACROS_SVH
`define ACCEL_TAP_GESTURE_DETECTOR_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, switched off while reset is held
`define ATGD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("atgd: assertion failed");

// Clocked check that also holds during reset
`define ATGD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("atgd: assertion failed");

`else

`define ATGD_ASSERT(lbl, clk, rst_n, prop)
`define ATGD_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> rtl/atgd_pkg.sv
// ----------------------------------------------------------------------------
// atgd_pkg
// Shared types and constants of the accelerometer tap detector.
// ----------------------------------------------------------------------------
`default_nettype none

package atgd_pkg;

    localparam int SQ_W    = 34;   // squared thresholds
    localparam int MS_W    = 16;   // cooldown and window
    localparam int EV_W    = 3;    // tap event code
    localparam int CIDX_W  = 3;    // register index

    // register indexes
    localparam logic [CIDX_W-1:0] CFG_ENABLE       = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_STILL_LOW    = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_STILL_HIGH   = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_TAP_JERK     = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_COOLDOWN     = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_DOUBLE_WIN   = 3'd5;

    // register reset values
    localparam logic [SQ_W-1:0] RST_STILL_LOW  = 34'd48486154;  // (0.85 g)^2
    localparam logic [SQ_W-1:0] RST_STILL_HIGH = 34'd88751473;  // (1.15 g)^2
    localparam logic [SQ_W-1:0] RST_TAP_JERK   = 34'd48486154;
    localparam logic [MS_W-1:0] RST_COOLDOWN   = 16'd300;
    localparam logic [MS_W-1:0] RST_DOUBLE_WIN = 16'd600;

    typedef enum logic [EV_W-1:0] {
        TAP_NONE     = 3'd0,
        TAP_Y        = 3'd1,
        TAP_X        = 3'd2,
        TAP_Z        = 3'd3,
        TAP_Z_DOUBLE = 3'd4,
        TAP_NO_AXIS  = 3'd5
    } t_tap_ev;

    typedef struct packed {
        logic            enable;
        logic [SQ_W-1:0] still_low_sq;
        logic [SQ_W-1:0] still_high_sq;
        logic [SQ_W-1:0] tap_jerk_sq;
        logic [MS_W-1:0] cooldown_ms;
        logic [MS_W-1:0] dbl_window_ms;
    } t_cfg;

endpackage

`default_nettype wire

>>> rtl/atgd_lane.sv
// ----------------------------------------------------------------------------
// atgd_lane
// One axis: squared sample, jerk against the previous sample and its square.
// ----------------------------------------------------------------------------
`default_nettype none

module atgd_lane import atgd_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_load,    // word accepted
    input  wire logic                          i_en,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic         [2*SAMPLE_BITS-1:0]   o_mag_sq,
    output logic         [SAMPLE_BITS-1:0]     o_jerk_abs,
    output logic         [2*SAMPLE_BITS-1:0]   o_jerk_sq
);

    localparam int S = SAMPLE_BITS;

    logic signed [S-1:0]   r_prev;
    logic        [S-1:0]   r_jerk_abs;
    logic        [2*S-1:0] r_mag_sq;
    logic        [2*S-1:0] r_jerk_sq;

    logic signed [S:0]     samp_ext;
    logic signed [S:0]     diff;
    logic        [S-1:0]   samp_abs;
    logic        [S-1:0]   diff_abs;

    always_comb begin
        samp_ext = {i_sample[S-1], i_sample};
        diff     = samp_ext - {r_prev[S-1], r_prev};
        // both magnitudes fit S bits: |sample| <= 2^(S-1), |diff| <= 2^S - 1
        samp_abs = samp_ext[S] ? S'(-samp_ext) : samp_ext[S-1:0];
        diff_abs = diff[S]     ? S'(-diff)     : diff[S-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (i_load && i_en) begin
            r_prev <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mag_sq   <= samp_abs * samp_abs;
            r_jerk_sq  <= diff_abs * diff_abs;
            r_jerk_abs <= diff_abs;
        end
    end

    assign o_mag_sq   = r_mag_sq;
    assign o_jerk_abs = r_jerk_abs;
    assign o_jerk_sq  = r_jerk_sq;

endmodule

`default_nettype wire

>>> rtl/atgd_merge.sv
// ----------------------------------------------------------------------------
// atgd_merge
// Sums the lane squares, checks the still band and tap threshold, classifies.
// ----------------------------------------------------------------------------
`default_nettype none
`include "accel_tap_gesture_detector_macros.svh"

module atgd_merge import atgd_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int TIME_BITS   = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_adv,      // load the result register
    input  wire t_cfg                       i_cfg,
    input  wire logic [TIME_BITS-1:0]       i_time,
    input  wire logic [2*SAMPLE_BITS-1:0]   i_mag_sq_x,
    input  wire logic [2*SAMPLE_BITS-1:0]   i_mag_sq_y,
    input  wire logic [2*SAMPLE_BITS-1:0]   i_mag_sq_z,
    input  wire logic [SAMPLE_BITS-1:0]     i_jerk_abs_x,
    input  wire logic [SAMPLE_BITS-1:0]     i_jerk_abs_y,
    input  wire logic [SAMPLE_BITS-1:0]     i_jerk_abs_z,
    input  wire logic [2*SAMPLE_BITS-1:0]   i_jerk_sq_x,
    input  wire logic [2*SAMPLE_BITS-1:0]   i_jerk_sq_y,
    input  wire logic [2*SAMPLE_BITS-1:0]   i_jerk_sq_z,
    output logic                            o_moving,
    output logic [EV_W-1:0]                 o_tap_event,
    output logic                            o_blackout
);

    localparam int T    = TIME_BITS;
    localparam int SUMW = 2 * SAMPLE_BITS + 2;
    localparam int CW   = (SUMW > SQ_W) ? SUMW : SQ_W;

    logic [T-1:0] r_last_tap;
    logic [T-1:0] r_last_ztap;
    logic         r_blackout;
    logic         r_moving;
    t_tap_ev      r_event;

    logic [T-1:0] n_last_tap;
    logic [T-1:0] n_last_ztap;
    logic         n_blackout;
    logic         n_moving;
    t_tap_ev      n_event;

    logic [CW-1:0] mag_sum;
    logic [CW-1:0] jerk_sum;
    logic [T-1:0]  dt_tap;
    logic [T-1:0]  dt_ztap;
    logic          tap_hit;
    logic          adv_dbl;    // word advancing as a double tap
    logic          adv_off;    // word advancing while disabled

    always_comb begin
        mag_sum  = CW'(i_mag_sq_x) + CW'(i_mag_sq_y) + CW'(i_mag_sq_z);
        jerk_sum = CW'(i_jerk_sq_x) + CW'(i_jerk_sq_y) + CW'(i_jerk_sq_z);
        dt_tap   = i_time - r_last_tap;      // wraps modulo 2^T
        dt_ztap  = i_time - r_last_ztap;
        tap_hit  = (jerk_sum > CW'(i_cfg.tap_jerk_sq))
                 && (dt_tap > T'(i_cfg.cooldown_ms));

        n_last_tap  = r_last_tap;
        n_last_ztap = r_last_ztap;
        n_blackout  = r_blackout;
        n_moving    = 1'b0;
        n_event     = TAP_NONE;

        if (i_cfg.enable) begin
            n_moving = (mag_sum < CW'(i_cfg.still_low_sq))
                     || (mag_sum > CW'(i_cfg.still_high_sq));
            if (tap_hit) begin
                n_last_tap = i_time;
                priority if (i_jerk_abs_y > i_jerk_abs_x && i_jerk_abs_y > i_jerk_abs_z) begin
                    n_event = TAP_Y;
                end else if (i_jerk_abs_x > i_jerk_abs_y && i_jerk_abs_x > i_jerk_abs_z) begin
                    n_event = TAP_X;
                end else if (i_jerk_abs_z > i_jerk_abs_y && i_jerk_abs_z > i_jerk_abs_x) begin
                    if (dt_ztap < T'(i_cfg.dbl_window_ms)) begin
                        n_blackout  = !r_blackout;
                        n_last_ztap = '0;
                        n_event     = TAP_Z_DOUBLE;
                    end else begin
                        n_last_ztap = i_time;
                        n_event     = TAP_Z;
                    end
                end else begin
                    n_event = TAP_NO_AXIS;
                end
            end
        end

        adv_dbl = i_adv && (n_event == TAP_Z_DOUBLE);
        adv_off = i_adv && !i_cfg.enable;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_tap  <= '0;
            r_last_ztap <= '0;
            r_blackout  <= 1'b0;
        end else if (i_adv) begin
            r_last_tap  <= n_last_tap;
            r_last_ztap <= n_last_ztap;
            r_blackout  <= n_blackout;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_moving <= n_moving;
            r_event  <= n_event;
        end
    end

    assign o_moving    = r_moving;
    assign o_tap_event = r_event;
    assign o_blackout  = r_blackout;

    // a double tap flips the flag, nothing else does
    `ATGD_ASSERT(a_double_toggles, i_clk, i_rst_n, adv_dbl |=> (r_blackout != $past(r_blackout)))
    `ATGD_ASSERT(a_flag_only_on_double, i_clk, i_rst_n, (i_adv && !adv_dbl) |=> $stable(r_blackout))
    `ATGD_ASSERT(a_disabled_quiet, i_clk, i_rst_n, adv_off |=> (r_event == TAP_NONE && !r_moving))

endmodule

`default_nettype wire

>>> rtl/accel_tap_gesture_detector.sv
// ----------------------------------------------------------------------------
// accel_tap_gesture_detector
// Tap, double-tap and motion detection on three-axis accelerometer samples.
// ----------------------------------------------------------------------------
// Takes one sample word per clock (X, Y, Z counts at 8192 per g plus a
// millisecond timestamp) and returns one result word for each: a motion flag
// (squared magnitude outside the still band), a tap code and the blackout
// flag as it stands after that sample. Three axis lanes square the sample and
// the jerk against the previous sample in the cycle after acceptance; a merge
// stage sums the squares, compares them against the thresholds, classifies the
// tap by its strictly dominant axis and updates the tap timers. The sustained
// rate is one word per cycle unless the output stalls: the tap timers and
// blackout flag are read and written within the merge stage alone, and the
// previous-sample registers in the lanes update at acceptance. All thresholds
// are squared values, time differences wrap modulo 2^TIME_BITS. Registers are
// written through a plain write port and should only change while idle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "accel_tap_gesture_detector_macros.svh"

module accel_tap_gesture_detector import atgd_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int TIME_BITS   = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration
    input  wire logic                          i_cfg_we,
    input  wire logic [CIDX_W-1:0]             i_cfg_idx,
    input  wire logic [SQ_W-1:0]               i_cfg_data,
    // sample words
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] i_accel_x,
    input  wire logic signed [SAMPLE_BITS-1:0] i_accel_y,
    input  wire logic signed [SAMPLE_BITS-1:0] i_accel_z,
    input  wire logic [TIME_BITS-1:0]          i_time_ms,
    // result words
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_moving,
    output logic [EV_W-1:0]                    o_tap_event,
    output logic                               o_blackout
);

    localparam int S = SAMPLE_BITS;

    t_cfg                 r_cfg;
    logic                 r_s1_vld;
    logic [TIME_BITS-1:0] r_s1_time;
    logic                 r_out_vld;

    logic in_acc;
    logic s1_adv;

    logic [2*S-1:0] mag_sq_x, mag_sq_y, mag_sq_z;
    logic [S-1:0]   jerk_abs_x, jerk_abs_y, jerk_abs_z;
    logic [2*S-1:0] jerk_sq_x, jerk_sq_y, jerk_sq_z;

    // --- register file ------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable        <= 1'b0;
            r_cfg.still_low_sq  <= RST_STILL_LOW;
            r_cfg.still_high_sq <= RST_STILL_HIGH;
            r_cfg.tap_jerk_sq   <= RST_TAP_JERK;
            r_cfg.cooldown_ms   <= RST_COOLDOWN;
            r_cfg.dbl_window_ms <= RST_DOUBLE_WIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ENABLE:     r_cfg.enable        <= i_cfg_data[0];
                CFG_STILL_LOW:  r_cfg.still_low_sq  <= i_cfg_data;
                CFG_STILL_HIGH: r_cfg.still_high_sq <= i_cfg_data;
                CFG_TAP_JERK:   r_cfg.tap_jerk_sq   <= i_cfg_data;
                CFG_COOLDOWN:   r_cfg.cooldown_ms   <= i_cfg_data[MS_W-1:0];
                CFG_DOUBLE_WIN: r_cfg.dbl_window_ms <= i_cfg_data[MS_W-1:0];
                default: ;  // unused indexes are dropped
            endcase
        end
    end

    // --- flow control ---------------------------------------------------------
    // stage 1 = lane registers, stage 2 = result register
    assign s1_adv     = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_time <= i_time_ms;
        end
    end

    // --- axis lanes -----------------------------------------------------------
    atgd_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (in_acc),
        .i_en       (r_cfg.enable),
        .i_sample   (i_accel_x),
        .o_mag_sq   (mag_sq_x),
        .o_jerk_abs (jerk_abs_x),
        .o_jerk_sq  (jerk_sq_x)
    );

    atgd_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (in_acc),
        .i_en       (r_cfg.enable),
        .i_sample   (i_accel_y),
        .o_mag_sq   (mag_sq_y),
        .o_jerk_abs (jerk_abs_y),
        .o_jerk_sq  (jerk_sq_y)
    );

    atgd_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_z (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (in_acc),
        .i_en       (r_cfg.enable),
        .i_sample   (i_accel_z),
        .o_mag_sq   (mag_sq_z),
        .o_jerk_abs (jerk_abs_z),
        .o_jerk_sq  (jerk_sq_z)
    );

    // --- merge and classify ---------------------------------------------------
    atgd_merge #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (s1_adv),
        .i_cfg        (r_cfg),
        .i_time       (r_s1_time),
        .i_mag_sq_x   (mag_sq_x),
        .i_mag_sq_y   (mag_sq_y),
        .i_mag_sq_z   (mag_sq_z),
        .i_jerk_abs_x (jerk_abs_x),
        .i_jerk_abs_y (jerk_abs_y),
        .i_jerk_abs_z (jerk_abs_z),
        .i_jerk_sq_x  (jerk_sq_x),
        .i_jerk_sq_y  (jerk_sq_y),
        .i_jerk_sq_z  (jerk_sq_z),
        .o_moving     (o_moving),
        .o_tap_event  (o_tap_event),
        .o_blackout   (o_blackout)
    );

    assign o_out_valid = r_out_vld;

    // a word moving on from the lanes always lands in the result register
    `ATGD_ASSERT(a_adv_fills_out, i_clk, i_rst_n, s1_adv |=> r_out_vld)
    // no acceptance while both stages are full and the output is stalled
    `ATGD_ASSERT(a_no_overrun, i_clk, i_rst_n, (r_s1_vld && r_out_vld && !i_out_ready) |-> !o_in_ready)
    // a word held in the lanes is never lost
    `ATGD_ASSERT(a_s1_holds, i_clk, i_rst_n, (r_s1_vld && !s1_adv) |=> r_s1_vld)
    // nothing is valid out of reset
    `ATGD_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (!r_s1_vld && !r_out_vld))

endmodule

`default_nettype wire
